// ===== hw/rtl/t3ttd_pkg.sv =====
package t3ttd_pkg;

   localparam int Wrap = 1024;
   localparam int WrapBits = $clog2(Wrap + 1);
   localparam int QueueDepth = 4;
   localparam int CsrAddrW = 3;

   localparam logic [31:0] SyncPeriodReset = 32'd100000;
   localparam logic [9:0] TickReset = 10'd5;

   localparam logic [5:0] ChanOverflow = 6'd63;
   localparam logic [5:0] ChanLimit = 6'd16;

   typedef enum logic [2:0] {
      KIND_OVERFLOW    = 3'd0,
      KIND_PHOTON      = 3'd1,
      KIND_MARKER      = 3'd2,
      KIND_BAD_PHOTON  = 3'd3,
      KIND_BAD_SPECIAL = 3'd4,
      KIND_NON_MONO    = 3'd5
   } kind_type;

   typedef enum logic {
      REG_SYNC_PERIOD = 1'b0,
      REG_TICK        = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [31:0] sync_period_ps;
      logic [9:0]  tick_ps;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  channel;
      logic [63:0] total;
      logic [14:0] fine_delay;
   } item_type;

endpackage

// ===== hw/rtl/t3ttd_if.sv =====
interface t3ttd_req_if;
   logic        valid;
   logic        ready;
   logic        special;
   logic [5:0]  channel;
   logic [9:0]  nsync;
   logic [14:0] fine_delay;

   modport source (output valid, output special, output channel, output nsync,
                   output fine_delay, input ready);
   modport sink (input valid, input special, input channel, input nsync,
                 input fine_delay, output ready);
endinterface

interface t3ttd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [5:0]  event_channel;
   logic [63:0] macro_time_ps;
   logic [24:0] micro_time_ps;
   logic        faulted;

   modport source (output valid, output kind, output event_channel, output macro_time_ps,
                   output micro_time_ps, output faulted, input ready);
   modport sink (input valid, input kind, input event_channel, input macro_time_ps,
                 input micro_time_ps, input faulted, output ready);
endinterface

// ===== hw/rtl/t3ttd_csr.sv =====
module t3ttd_csr
   import t3ttd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output cfg_type             cfg
);

   logic [31:0] sync_period_ff, sync_period_in;
   logic [9:0]  tick_ff, tick_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite && pready;

   always_comb begin
      sync_period_in = sync_period_ff;
      tick_in = tick_ff;
      if (wr_en) begin
         unique case (reg_index_type'(paddr[2]))
            REG_SYNC_PERIOD: sync_period_in = pwdata;
            REG_TICK:        tick_in = pwdata[9:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_SYNC_PERIOD: prdata = sync_period_ff;
         REG_TICK:        prdata = {22'd0, tick_ff};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_period_ff <= SyncPeriodReset;
         tick_ff <= TickReset;
      end else begin
         sync_period_ff <= sync_period_in;
         tick_ff <= tick_in;
      end
   end

   assign cfg.sync_period_ps = sync_period_ff;
   assign cfg.tick_ps = tick_ff;

endmodule

// ===== hw/rtl/t3ttd_front.sv =====
module t3ttd_front
   import t3ttd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   t3ttd_req_if.sink       req_bus,
   output logic            push_valid,
   input  logic            push_ready,
   output item_type        push_data
);

   localparam logic [WrapBits-1:0] WrapVal = WrapBits'(Wrap);

   logic [63:0] overflow_ff, overflow_in;
   logic [WrapBits+9:0] wrap_syncs;
   logic [63:0] overflow_sum;
   kind_type    kind;
   logic        transfer;

   assign push_valid = req_bus.valid;
   assign req_bus.ready = push_ready;
   assign transfer = req_bus.valid && push_ready;

   assign wrap_syncs = (WrapBits+10)'(WrapVal) * (WrapBits+10)'(req_bus.nsync);
   assign overflow_sum = overflow_ff + 64'(wrap_syncs);

   always_comb begin
      if (!req_bus.special) begin
         kind = (req_bus.channel >= ChanLimit) ? KIND_BAD_PHOTON : KIND_PHOTON;
      end else if (req_bus.channel == ChanOverflow) begin
         kind = KIND_OVERFLOW;
      end else if (req_bus.channel != 6'd0 && req_bus.channel < ChanLimit) begin
         kind = KIND_MARKER;
      end else begin
         kind = KIND_BAD_SPECIAL;
      end
   end

   always_comb begin
      push_data.kind = kind;
      push_data.channel = req_bus.channel;
      push_data.fine_delay = req_bus.fine_delay;
      push_data.total = (kind == KIND_OVERFLOW) ? overflow_sum
                        : overflow_ff + 64'(req_bus.nsync);
      overflow_in = (transfer && kind == KIND_OVERFLOW) ? overflow_sum : overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff <= 64'd0;
      end else begin
         overflow_ff <= overflow_in;
      end
   end

endmodule

// ===== hw/rtl/t3ttd_queue.sv =====
module t3ttd_queue
   import t3ttd_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] Full = CntW'(DEPTH);

   item_type            mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid = (count_ff != '0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/t3ttd_back.sv =====
module t3ttd_back
   import t3ttd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  item_type   pop_data,
   t3ttd_rsp_if.source rsp_bus
);

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  channel;
      logic [63:0] lo_prod;
      logic [31:0] hi_prod;
      logic [24:0] micro;
   } s1_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  channel;
      logic [63:0] macro;
      logic [24:0] micro;
   } s2_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  channel;
      logic [63:0] macro;
      logic [24:0] micro;
      logic        faulted;
   } out_type;

   logic        en, step;
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   out_type     rsp_ff, rsp_in, res;
   logic [63:0] last_photon_ff, last_photon_in;
   logic [63:0] last_marker_ff, last_marker_in;
   logic        fault_ff, fault_in;
   kind_type    fault_kind_ff, fault_kind_in;

   assign en = !rsp_valid_ff || rsp_bus.ready;
   assign pop_ready = en;
   assign step = en && s2_valid_ff;

   always_comb begin
      s1_in.kind = pop_data.kind;
      s1_in.channel = pop_data.channel;
      s1_in.lo_prod = {32'd0, pop_data.total[31:0]} * {32'd0, cfg.sync_period_ps};
      s1_in.hi_prod = pop_data.total[63:32] * cfg.sync_period_ps;
      s1_in.micro = 25'(cfg.tick_ps) * 25'(pop_data.fine_delay);
      s1_valid_in = en ? pop_valid : s1_valid_ff;
      if (!en) begin
         s1_in = s1_ff;
      end
   end

   always_comb begin
      s2_in.kind = s1_ff.kind;
      s2_in.channel = s1_ff.channel;
      s2_in.macro = s1_ff.lo_prod + {s1_ff.hi_prod, 32'd0};
      s2_in.micro = s1_ff.micro;
      s2_valid_in = en ? s1_valid_ff : s2_valid_ff;
      if (!en) begin
         s2_in = s2_ff;
      end
   end

   always_comb begin
      res.kind = s2_ff.kind;
      res.channel = s2_ff.channel;
      res.macro = s2_ff.macro;
      res.micro = s2_ff.micro;
      res.faulted = 1'b0;
      last_photon_in = last_photon_ff;
      last_marker_in = last_marker_ff;
      if (fault_ff) begin
         res = '{kind: fault_kind_ff, channel: 6'd0, macro: 64'd0, micro: 25'd0,
                 faulted: 1'b1};
      end else begin
         unique case (s2_ff.kind)
            KIND_OVERFLOW: begin
               res.channel = 6'd0;
               res.micro = 25'd0;
            end
            KIND_PHOTON: begin
               if (s2_ff.macro < last_photon_ff) begin
                  res.kind = KIND_NON_MONO;
                  res.channel = 6'd0;
                  res.micro = 25'd0;
                  res.faulted = 1'b1;
               end else begin
                  last_photon_in = s2_ff.macro;
               end
            end
            KIND_MARKER: begin
               res.micro = 25'd0;
               if (s2_ff.macro < last_marker_ff) begin
                  res.kind = KIND_NON_MONO;
                  res.channel = 6'd0;
                  res.faulted = 1'b1;
               end else begin
                  last_marker_in = s2_ff.macro;
               end
            end
            default: begin
               res.channel = 6'd0;
               res.macro = 64'd0;
               res.micro = 25'd0;
               res.faulted = 1'b1;
            end
         endcase
      end
      fault_in = res.faulted;
      fault_kind_in = res.kind;
      if (!step) begin
         last_photon_in = last_photon_ff;
         last_marker_in = last_marker_ff;
         fault_in = fault_ff;
         fault_kind_in = fault_kind_ff;
      end
      rsp_in = en ? res : rsp_ff;
      rsp_valid_in = en ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_photon_ff <= 64'd0;
         last_marker_ff <= 64'd0;
         fault_ff <= 1'b0;
         fault_kind_ff <= KIND_OVERFLOW;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_photon_ff <= last_photon_in;
         last_marker_ff <= last_marker_in;
         fault_ff <= fault_in;
         fault_kind_ff <= fault_kind_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind = rsp_ff.kind;
   assign rsp_bus.event_channel = rsp_ff.channel;
   assign rsp_bus.macro_time_ps = rsp_ff.macro;
   assign rsp_bus.micro_time_ps = rsp_ff.micro;
   assign rsp_bus.faulted = rsp_ff.faulted;

endmodule

// ===== hw/rtl/t3_time_tag_record_decoder_core.sv =====
// T3 time-tag record decoder.
// A record passes the queue, then the product, sum and compare registers.
// One record per cycle unless stalled; split 64x32 sync-period multiply is pipelined.
// Reset (synchronous): sync period 100000 ps, tick 5 ps, overflow count, last photon and
// marker times and the fault flag cleared; no clearing pass, records are taken right away.
module t3_time_tag_record_decoder_core
   import t3ttd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   t3ttd_req_if.sink           req_bus,
   t3ttd_rsp_if.source         rsp_bus
);

   cfg_type  cfg;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_data, pop_data;

   t3ttd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   t3ttd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   t3ttd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   t3ttd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== bench/tb_t3_time_tag_record_decoder_core.sv =====
module tb_t3_time_tag_record_decoder_core;
   import t3ttd_pkg::*;

   localparam int unsigned RunLimitCycles = 400_000;
   localparam int RandomPerPhase = 130;
   localparam int NoiseRecords = 40;
   localparam int WrapRecords = 8;

   typedef struct packed {
      logic        special;
      logic [5:0]  channel;
      logic [9:0]  nsync;
      logic [14:0] fine_delay;
   } record_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  channel;
      logic [63:0] macro_ps;
      logic [24:0] micro_ps;
      logic        faulted;
   } tag_event_type;

   typedef struct {
      logic [31:0] period;
      logic [9:0]  tick;
      logic [63:0] overflow_syncs;
      logic [63:0] last_photon_ps;
      logic [63:0] last_marker_ps;
      logic        fault;
      kind_type    fault_kind;
   } decoder_state_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   t3ttd_req_if req_bus ();
   t3ttd_rsp_if rsp_bus ();

   t3_time_tag_record_decoder_core dut (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   record_type        pending_records[$];
   tag_event_type     expected_events[$];
   decoder_state_type gen_state;
   decoder_state_type model_state;
   logic [9:0]        last_sync[2];

   logic steady;
   logic req_taken;
   int   send_gap = 0;
   int   stall_left = 0;
   logic long_stall_done = 1'b0;
   int   mismatch_count = 0;
   int   results_seen = 0;
   int   photons_seen = 0;
   int   markers_seen = 0;
   int   overflows_seen = 0;
   int   faults_seen = 0;
   kind_type fault_kind_seen = KIND_OVERFLOW;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic decoder_state_type reset_decoder();
      decoder_state_type s;
      s.period = SyncPeriodReset;
      s.tick = TickReset;
      s.overflow_syncs = '0;
      s.last_photon_ps = '0;
      s.last_marker_ps = '0;
      s.fault = 1'b0;
      s.fault_kind = KIND_OVERFLOW;
      return s;
   endfunction

   function automatic tag_event_type decode_record(inout decoder_state_type s,
                                                   input record_type r);
      tag_event_type ev;
      logic [63:0] total;
      logic [63:0] macro;
      ev = '0;
      if (s.fault) begin
         ev.kind = s.fault_kind;
         ev.faulted = 1'b1;
         return ev;
      end
      total = s.overflow_syncs + 64'(r.nsync);
      macro = total * 64'(s.period);
      if (!r.special) begin
         if (r.channel >= ChanLimit) begin
            ev.kind = KIND_BAD_PHOTON;
         end else if (macro < s.last_photon_ps) begin
            ev.kind = KIND_NON_MONO;
            ev.macro_ps = macro;
         end else begin
            s.last_photon_ps = macro;
            ev.kind = KIND_PHOTON;
            ev.channel = r.channel;
            ev.macro_ps = macro;
            ev.micro_ps = {15'd0, s.tick} * {10'd0, r.fine_delay};
            return ev;
         end
      end else if (r.channel == ChanOverflow) begin
         s.overflow_syncs = s.overflow_syncs + 64'(Wrap) * 64'(r.nsync);
         ev.kind = KIND_OVERFLOW;
         ev.macro_ps = s.overflow_syncs * 64'(s.period);
         return ev;
      end else if (r.channel != 6'd0 && r.channel < ChanLimit) begin
         if (macro < s.last_marker_ps) begin
            ev.kind = KIND_NON_MONO;
            ev.macro_ps = macro;
         end else begin
            s.last_marker_ps = macro;
            ev.kind = KIND_MARKER;
            ev.channel = r.channel;
            ev.macro_ps = macro;
            return ev;
         end
      end else begin
         ev.kind = KIND_BAD_SPECIAL;
      end
      s.fault = 1'b1;
      s.fault_kind = ev.kind;
      ev.faulted = 1'b1;
      return ev;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic queue_record(input logic special, input logic [5:0] channel,
                               input logic [9:0] nsync, input logic [14:0] fine_delay);
      record_type r;
      r = '{special, channel, nsync, fine_delay};
      void'(decode_record(gen_state, r));
      if (special && channel == ChanOverflow) begin
         if (nsync != 10'd0) begin
            last_sync[0] = '0;
            last_sync[1] = '0;
         end
      end else if (channel < ChanLimit) begin
         last_sync[special] = nsync;
      end
      pending_records.push_back(r);
   endtask

   // mostly rising sync counts; a backward step turns into an overflow transfer
   task automatic queue_clean_record();
      record_type r;
      decoder_state_type trial;
      tag_event_type ev;
      int unsigned pick;
      int unsigned next;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0: r.fine_delay = '0;
         1: r.fine_delay = '1;
         default: r.fine_delay = 15'($urandom);
      endcase
      if (pick < 20) begin
         r.special = 1'b1;
         r.channel = ChanOverflow;
         case ($urandom_range(0, 15))
            0: r.nsync = 10'd1023;
            1: r.nsync = 10'd0;
            2: r.nsync = 10'($urandom_range(0, 1023));
            default: r.nsync = 10'($urandom_range(1, 3));
         endcase
      end else begin
         r.special = (pick >= 60);
         r.channel = r.special ? 6'($urandom_range(1, 15)) : 6'($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            0: r.nsync = last_sync[r.special];
            1, 2, 3: r.nsync = 10'($urandom_range(0, 1023));
            default: begin
               next = int'(last_sync[r.special]) + $urandom_range(1, 64);
               r.nsync = (next > 1023) ? 10'd1023 : 10'(next);
            end
         endcase
      end
      trial = gen_state;
      ev = decode_record(trial, r);
      if (ev.faulted) begin
         r.special = 1'b1;
         r.channel = ChanOverflow;
         r.nsync = 10'($urandom_range(1, 4));
      end
      queue_record(r.special, r.channel, r.nsync, r.fine_delay);
   endtask

   task automatic csr_read(input reg_index_type idx, output logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] stored;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_TICK) begin
         stored = {22'd0, value[9:0]};
         gen_state.tick = value[9:0];
         model_state.tick = value[9:0];
      end else begin
         stored = value;
         gen_state.period = value;
         model_state.period = value;
      end
      csr_read(idx, readback);
      if (readback !== stored)
         report_mismatch("register read-back", 64'(readback), 64'(stored));
   endtask

   task automatic wait_drained();
      while (pending_records.size() != 0 || expected_events.size() != 0) @(posedge clock);
   endtask

   // record driver
   always @(posedge clock) begin : record_accept
      record_type r;
      if (!reset && req_bus.valid && req_bus.ready) begin
         r = pending_records.pop_front();
         expected_events.push_back(decode_record(model_state, r));
      end
      req_taken <= !reset && req_bus.valid && req_bus.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_taken)) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= $urandom_range(0, 15);
         end else if (pending_records.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.special <= pending_records[0].special;
            req_bus.channel <= pending_records[0].channel;
            req_bus.nsync <= pending_records[0].nsync;
            req_bus.fine_delay <= pending_records[0].fine_delay;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // event monitor
   always @(posedge clock) begin : event_check
      tag_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_events.size() == 0) begin
            report_mismatch("event with no record pending", 64'(rsp_bus.kind), '0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_bus.kind !== want.kind)
               report_mismatch("kind", 64'(rsp_bus.kind), 64'(want.kind));
            if (rsp_bus.event_channel !== want.channel)
               report_mismatch("event_channel", 64'(rsp_bus.event_channel),
                               64'(want.channel));
            if (rsp_bus.macro_time_ps !== want.macro_ps)
               report_mismatch("macro_time_ps", rsp_bus.macro_time_ps, want.macro_ps);
            if (rsp_bus.micro_time_ps !== want.micro_ps)
               report_mismatch("micro_time_ps", 64'(rsp_bus.micro_time_ps),
                               64'(want.micro_ps));
            if (rsp_bus.faulted !== want.faulted)
               report_mismatch("faulted", 64'(rsp_bus.faulted), 64'(want.faulted));
            if (want.faulted) begin
               faults_seen++;
               fault_kind_seen = want.kind;
            end else if (want.kind == KIND_PHOTON) begin
               photons_seen++;
            end else if (want.kind == KIND_MARKER) begin
               markers_seen++;
            end else begin
               overflows_seen++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!long_stall_done && results_seen >= 300) begin
         // long backpressure so the record input stalls
         rsp_bus.ready <= 1'b0;
         stall_left <= 79;
         long_stall_done <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      #(RunLimitCycles * 12);
      $display("Timed out waiting for the decoder to drain");
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [31:0] rd;
      reset = 1'b1;
      steady = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.special = 1'b0;
      req_bus.channel = '0;
      req_bus.nsync = '0;
      req_bus.fine_delay = '0;
      rsp_bus.ready = 1'b0;
      gen_state = reset_decoder();
      model_state = reset_decoder();
      last_sync[0] = '0;
      last_sync[1] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_read(REG_SYNC_PERIOD, rd);
      if (rd !== SyncPeriodReset)
         report_mismatch("sync period after reset", 64'(rd), 64'(SyncPeriodReset));
      csr_read(REG_TICK, rd);
      if (rd !== 32'(TickReset))
         report_mismatch("tick after reset", 64'(rd), 64'(TickReset));

      // period only ever grows from here, so clean sequences stay monotonic
      set_register(REG_SYNC_PERIOD, 32'd1);
      @(posedge clock);
      queue_record(1'b0, 6'd0, 10'd0, 15'd0);
      queue_record(1'b0, 6'd15, 10'd1023, 15'h7FFF);
      queue_record(1'b0, 6'd7, 10'd1023, 15'd12345);
      queue_record(1'b1, 6'd1, 10'd0, 15'd0);
      queue_record(1'b1, 6'd15, 10'd512, 15'd0);
      queue_record(1'b1, 6'd15, 10'd512, 15'h7FFF);
      queue_record(1'b1, ChanOverflow, 10'd0, 15'd0);
      queue_record(1'b1, ChanOverflow, 10'd1, 15'd0);
      queue_record(1'b0, 6'd3, 10'd0, 15'd1);
      queue_record(1'b1, 6'd1, 10'd0, 15'd0);
      queue_record(1'b1, ChanOverflow, 10'd1023, 15'd0);
      queue_record(1'b0, 6'd10, 10'd1023, 15'h7FFF);
      queue_record(1'b1, 6'd8, 10'd1023, 15'd0);
      queue_record(1'b1, ChanOverflow, 10'd512, 15'h7FFF);
      queue_record(1'b0, 6'd0, 10'd0, 15'h5555);
      queue_record(1'b0, 6'd15, 10'd1, 15'h2AAA);
      queue_record(1'b1, 6'd9, 10'd2, 15'h7FFF);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_register(REG_TICK, 32'hABCD_E7FF);
            1: begin
               set_register(REG_SYNC_PERIOD, SyncPeriodReset);
               set_register(REG_TICK, 32'd1);
            end
            2: begin
               set_register(REG_SYNC_PERIOD, $urandom_range(100001, 32'h7FFF_FFFF));
               set_register(REG_TICK, $urandom_range(2, 1022));
            end
            3: begin
               set_register(REG_SYNC_PERIOD, $urandom_range(32'h8000_0000, 32'hFFFF_FFFE));
               set_register(REG_TICK, 32'(TickReset));
            end
            4: begin
               set_register(REG_SYNC_PERIOD, 32'hFFFF_FFFF);
               set_register(REG_TICK, $urandom_range(1, 1023));
            end
            default: steady = 1'b1;
         endcase
         @(posedge clock);
         repeat (RandomPerPhase) queue_clean_record();
         wait_drained();
      end

      // a few full-size overflow transfers at the widest period
      repeat (WrapRecords) queue_record(1'b1, ChanOverflow, 10'd1023, 15'($urandom));

      case ($urandom_range(0, 2))
         0: queue_record(1'b0, 6'($urandom_range(16, 63)), 10'($urandom), 15'($urandom));
         1: queue_record(1'b1, ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(16, 62)),
                         10'($urandom), 15'($urandom));
         default: begin
            queue_record(1'b0, 6'd3, 10'd1023, 15'($urandom));
            queue_record(1'b0, 6'd3, 10'd0, 15'($urandom));
         end
      endcase
      repeat (NoiseRecords)
         queue_record(1'($urandom), 6'($urandom), 10'($urandom), 15'($urandom));
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Checked %0d events: %0d photons, %0d markers, %0d overflows, %0d faulted (%s)",
               results_seen, photons_seen, markers_seen, overflows_seen, faults_seen,
               fault_kind_seen.name());
      $display("Sync period swept 1 ps to 4294967295 ps, tick 1 to 1023 ps, long stall hit");
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
